// ----- rtl/core/button_press_hold_release_classifier_unit_assert.svh -----
// Assertion macros shared by the checker of the button classifier.
// No dependencies; include by bare file name.
`ifndef BUTTON_PRESS_HOLD_RELEASE_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_HOLD_RELEASE_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BPHR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BPHR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset was high.
`define BPHR_ASSERT_POST_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) $past(reset) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bphr_pkg.sv -----
// Types and constants of the button classifier.
// No dependencies; imported by every module of the block but bphr_ram.
package bphr_pkg;

   // Kind of the last event stored per button.
   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_PRESS   = 3'd1,
      KIND_DOUBLE  = 3'd2,
      KIND_HOLD    = 3'd3,
      KIND_RELEASE = 3'd4
   } kind_type;

   // Reported event codes.
   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_DOUBLE  = 2'd1,
      EV_HOLD    = 2'd2,
      EV_RELEASE = 2'd3
   } ev_type;

   // Polled action codes.
   localparam logic [1:0] ACT_IDLE    = 2'd0;
   localparam logic [1:0] ACT_PRESS   = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HOLD_MIN    = 2'd0;
   localparam logic [1:0] CSR_DOUBLE_MIN  = 2'd1;
   localparam logic [1:0] CSR_DOUBLE_MAX  = 2'd2;
   localparam logic [1:0] CSR_RELEASE_MIN = 2'd3;

   localparam logic [15:0] HOLD_MIN_RESET    = 16'd500;
   localparam logic [15:0] DOUBLE_MIN_RESET  = 16'd0;
   localparam logic [15:0] DOUBLE_MAX_RESET  = 16'd300;
   localparam logic [15:0] RELEASE_MIN_RESET = 16'd0;

   typedef struct packed {
      logic [2:0]  button_index;
      logic [1:0]  action;
      logic [31:0] now_ms;
      logic [31:0] poll_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [2:0]  event_button;
      logic [31:0] event_time;
      logic [31:0] event_poll;
      logic [31:0] event_duration;
   } rsp_type;

   // One entry of the per-button state memory.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] stamp_ms;
   } entry_type;

   typedef struct packed {
      logic [15:0] hold_min_ms;
      logic [15:0] double_min_ms;
      logic [15:0] double_max_ms;
      logic [15:0] release_min_ms;
   } cfg_type;

   // Decision of the classifier for one sample.
   typedef struct packed {
      logic      wr_en;
      entry_type entry;
      logic      ev_valid;
      rsp_type   rsp;
   } cls_result_type;

endpackage

// ----- rtl/core/button_press_hold_release_classifier_unit.sv -----
// Button press / double press / hold / release classifier, top level.
// Pipeline: stage 1 and the output register. Throughput: one sample per cycle
// while the result side does not stall; the state RAM does a read per sample and
// a write as it leaves stage 1; a bypass register closes the read-after-write gap.
// Reset: synchronous, clears the per-button valid bits and loads register defaults
// with no clearing pass. Depends on bphr_pkg, bphr_ram, bphr_classify.
module button_press_hold_release_classifier_unit #(
   parameter int NUM_BUTTONS = 8,
   localparam int AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bphr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bphr_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data
);
   import bphr_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers: user writes only while the block is idle; unenforced.
   // ---------------------------------------------------------------
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HOLD_MIN:    cfg_in.hold_min_ms    = csr_wr_data;
            CSR_DOUBLE_MIN:  cfg_in.double_min_ms  = csr_wr_data;
            CSR_DOUBLE_MAX:  cfg_in.double_max_ms  = csr_wr_data;
            CSR_RELEASE_MIN: cfg_in.release_min_ms = csr_wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_min_ms    <= HOLD_MIN_RESET;
         cfg_ff.double_min_ms  <= DOUBLE_MIN_RESET;
         cfg_ff.double_max_ms  <= DOUBLE_MAX_RESET;
         cfg_ff.release_min_ms <= RELEASE_MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake. Stage 1 holds the sample whose RAM read is in flight;
   // the output register parts it from the result side so that a new
   // transfer is taken while a result still waits, if stage 1 is empty.
   // ---------------------------------------------------------------
   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_req_ff;
   logic             s1_in_range_ff;
   logic [AddrW-1:0] s1_addr_ff;
   logic             s1_advance;
   logic             req_accept;

   logic             out_valid_ff, out_valid_in;
   rsp_type          out_payload_ff;

   cls_result_type   cls;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // State RAM address and range check of the incoming sample.
   // ---------------------------------------------------------------
   logic [AddrW-1:0] req_addr;
   logic             req_in_range;

   assign req_addr     = AddrW'(req_payload.button_index);
   assign req_in_range = (32'(req_payload.button_index) < NUM_BUTTONS);

   // Per-button valid bits: an entry never written reads as no event at time zero.
   logic [NUM_BUTTONS-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff;

   // Bypass: the stage 1 write lands on the same edge as the next read.
   logic      fwd_hit_ff;
   entry_type fwd_entry_ff;
   logic      wr_en;

   assign wr_en = s1_advance && cls.wr_en;

   logic [$bits(entry_type)-1:0] ram_rd_data;

   bphr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_BUTTONS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (cls.entry),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Pick the freshest view of the entry.
   entry_type s1_entry;

   always_comb begin
      if (fwd_hit_ff) begin
         s1_entry = fwd_entry_ff;
      end else if (rd_valid_ff) begin
         s1_entry = entry_type'(ram_rd_data);
      end else begin
         s1_entry.kind     = KIND_NONE;
         s1_entry.stamp_ms = '0;
      end
   end

   bphr_classify u_classify (
      .req      (s1_req_ff),
      .in_range (s1_in_range_ff),
      .entry    (s1_entry),
      .cfg      (cfg_ff),
      .result   (cls)
   );

   // ---------------------------------------------------------------
   // Next state of the control registers.
   // ---------------------------------------------------------------
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[s1_addr_ff] = 1'b1;
      end

      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      // advance the output register when it is empty or its transfer completes
      out_valid_in = out_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = s1_valid_ff && cls.ev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (req_accept) begin
            fwd_hit_ff <= wr_en && (s1_addr_ff == req_addr);
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff      <= req_payload;
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
         rd_valid_ff    <= valid_ff[req_addr];
         fwd_entry_ff   <= cls.entry;
      end
      if (s1_advance) begin
         out_payload_ff <= cls.rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

endmodule

// ----- rtl/core/bphr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bphr_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bphr_classify.sv -----
// Per-sample classification: next state of one button and the event it gives.
// Depends on bphr_pkg.
module bphr_classify (
   input  bphr_pkg::req_type        req,
   input  logic                     in_range,
   input  bphr_pkg::entry_type      entry,
   input  bphr_pkg::cfg_type        cfg,
   output bphr_pkg::cls_result_type result
);
   import bphr_pkg::*;

   logic [31:0] elapsed;
   logic        down;

   assign elapsed = req.now_ms - entry.stamp_ms;
   assign down    = (entry.kind == KIND_PRESS) || (entry.kind == KIND_DOUBLE) ||
                    (entry.kind == KIND_HOLD);

   always_comb begin
      result                    = '0;
      result.entry              = entry;
      result.rsp.event_button   = req.button_index;
      result.rsp.event_poll     = req.poll_index;
      result.rsp.event_time     = req.now_ms;
      result.rsp.event_duration = '0;
      if (in_range) begin
         case (req.action)
            ACT_PRESS: begin
               if (down) begin
                  if ((entry.kind == KIND_HOLD) || (elapsed >= {16'd0, cfg.hold_min_ms})) begin
                     // hold keeps the press time
                     result.wr_en              = 1'b1;
                     result.entry.kind         = KIND_HOLD;
                     result.ev_valid           = 1'b1;
                     result.rsp.event_kind     = EV_HOLD;
                     result.rsp.event_time     = entry.stamp_ms;
                     result.rsp.event_duration = elapsed;
                  end
               end else if ((entry.kind == KIND_RELEASE) &&
                            (elapsed >= {16'd0, cfg.double_min_ms}) &&
                            (elapsed <= {16'd0, cfg.double_max_ms})) begin
                  result.wr_en          = 1'b1;
                  result.entry.kind     = KIND_DOUBLE;
                  result.entry.stamp_ms = req.now_ms;
                  result.ev_valid       = 1'b1;
                  result.rsp.event_kind = EV_DOUBLE;
               end else begin
                  result.wr_en          = 1'b1;
                  result.entry.kind     = KIND_PRESS;
                  result.entry.stamp_ms = req.now_ms;
                  result.ev_valid       = 1'b1;
                  result.rsp.event_kind = EV_PRESS;
               end
            end
            ACT_RELEASE: begin
               if (down && (elapsed >= {16'd0, cfg.release_min_ms})) begin
                  result.wr_en              = 1'b1;
                  result.entry.kind         = KIND_RELEASE;
                  result.entry.stamp_ms     = req.now_ms;
                  result.ev_valid           = 1'b1;
                  result.rsp.event_kind     = EV_RELEASE;
                  result.rsp.event_duration = elapsed;
               end
            end
            default: begin
               // idle and the unused code: drop
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/bphr_checker.sv -----
// Port-level checker of the button classifier and its bind to the top level.
// Depends on bphr_pkg and button_press_hold_release_classifier_unit_assert.svh.
`include "button_press_hold_release_classifier_unit_assert.svh"

module bphr_checker #(
   parameter int NUM_BUTTONS = 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bphr_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bphr_pkg::rsp_type rsp_payload
);
   import bphr_pkg::*;

   logic rsp_no_duration;
   logic req_seen;

   assign rsp_no_duration = (rsp_payload.event_kind == EV_PRESS) ||
                            (rsp_payload.event_kind == EV_DOUBLE);
   assign req_seen        = req_valid && (req_payload.action != ACT_IDLE);

   // a stalled result holds
   `BPHR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // only configured buttons report events
   `BPHR_ASSERT_IMP(a_rsp_button, rsp_valid, 32'(rsp_payload.event_button) < NUM_BUTTONS, "event for a missing button")

   // press and double press carry no duration
   `BPHR_ASSERT_IMP(a_rsp_press_dur, rsp_valid && rsp_no_duration, rsp_payload.event_duration == 32'd0, "press with nonzero duration")

   // the block is empty and ready right after reset
   `BPHR_ASSERT_POST_RESET(a_reset_empty, !rsp_valid && !req_stall, "not empty after reset")

   // a sample with an action offered after reset needs no stall to be seen empty
   `BPHR_ASSERT_POST_RESET(a_reset_take, !(req_seen && req_stall), "sample stalled after reset")

endmodule

bind button_press_hold_release_classifier_unit bphr_checker #(
   .NUM_BUTTONS (NUM_BUTTONS)
) u_bphr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- sim/button_press_hold_release_classifier_unit_checker.sv -----
// Checker for the button classifier: watches the sample, result and register ports,
// predicts each event from its own per-button table and compares the results in order.
// Depends on bphr_pkg.
module button_press_hold_release_classifier_unit_checker #(
   parameter int NUM_BUTTONS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  bphr_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  bphr_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import bphr_pkg::*;

   kind_type    btn_kind  [NUM_BUTTONS];
   logic [31:0] btn_stamp [NUM_BUTTONS];
   cfg_type     thresholds;
   rsp_type     pending_events[$];
   int          failures = 0;
   int          pending = 0;

   assign fail_count    = failures;
   assign pending_count = pending;

   // Classify one sample against the table; returns 1 when it gives an event.
   function automatic bit classify_sample(input req_type s, output rsp_type ev);
      int unsigned b;
      logic [31:0] elapsed;
      bit          down;
      ev = '0;
      b  = s.button_index;
      if (b >= NUM_BUTTONS)
         return 1'b0;
      elapsed = s.now_ms - btn_stamp[b];
      down    = (btn_kind[b] == KIND_PRESS) || (btn_kind[b] == KIND_DOUBLE) ||
                (btn_kind[b] == KIND_HOLD);
      ev.event_button = s.button_index;
      ev.event_poll   = s.poll_index;
      if (s.action == ACT_PRESS) begin
         if (down) begin
            if (btn_kind[b] != KIND_HOLD && elapsed < thresholds.hold_min_ms)
               return 1'b0;
            // hold keeps the press time
            btn_kind[b]       = KIND_HOLD;
            ev.event_kind     = EV_HOLD;
            ev.event_time     = btn_stamp[b];
            ev.event_duration = elapsed;
            return 1'b1;
         end
         if (btn_kind[b] == KIND_RELEASE && elapsed >= thresholds.double_min_ms &&
             elapsed <= thresholds.double_max_ms) begin
            btn_kind[b]   = KIND_DOUBLE;
            ev.event_kind = EV_DOUBLE;
         end else begin
            btn_kind[b]   = KIND_PRESS;
            ev.event_kind = EV_PRESS;
         end
         btn_stamp[b]  = s.now_ms;
         ev.event_time = s.now_ms;
         return 1'b1;
      end
      if (s.action == ACT_RELEASE && down && elapsed >= thresholds.release_min_ms) begin
         btn_kind[b]       = KIND_RELEASE;
         btn_stamp[b]      = s.now_ms;
         ev.event_kind     = EV_RELEASE;
         ev.event_time     = s.now_ms;
         ev.event_duration = elapsed;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type ev;
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_kind[i]  = KIND_NONE;
            btn_stamp[i] = '0;
         end
         thresholds.hold_min_ms    = HOLD_MIN_RESET;
         thresholds.double_min_ms  = DOUBLE_MIN_RESET;
         thresholds.double_max_ms  = DOUBLE_MAX_RESET;
         thresholds.release_min_ms = RELEASE_MIN_RESET;
         pending_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               $error("unexpected event: kind %0d button %0d time 0x%0h",
                      rsp_payload.event_kind, rsp_payload.event_button,
                      rsp_payload.event_time);
               failures++;
            end else begin
               want = pending_events.pop_front();
               check_field("event_kind", want.event_kind, rsp_payload.event_kind);
               check_field("event_button", want.event_button, rsp_payload.event_button);
               check_field("event_time", want.event_time, rsp_payload.event_time);
               check_field("event_poll", want.event_poll, rsp_payload.event_poll);
               check_field("event_duration", want.event_duration,
                           rsp_payload.event_duration);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HOLD_MIN:    thresholds.hold_min_ms    = csr_wr_data;
               CSR_DOUBLE_MIN:  thresholds.double_min_ms  = csr_wr_data;
               CSR_DOUBLE_MAX:  thresholds.double_max_ms  = csr_wr_data;
               CSR_RELEASE_MIN: thresholds.release_min_ms = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (classify_sample(req_payload, ev))
               pending_events.push_back(ev);
         end
      end
      pending = pending_events.size();
   end

endmodule

// ----- sim/button_press_hold_release_classifier_unit_test.sv -----
// Testbench top for the button classifier: clock, reset, sample stimulus, register
// settings, result stalls and the verdict. Depends on bphr_pkg, the block and
// button_press_hold_release_classifier_unit_checker.
module button_press_hold_release_classifier_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bphr_pkg::*;

   localparam int NUM_BUTTONS  = 8;
   localparam int LIMIT_CYCLES = 400000;
   // margin past the last predicted result, so that the pipeline runs dry
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 225;
   localparam int NUM_PHASES   = 8;
   // action code with no meaning; the block treats it as idle
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_HOLD_MIN;
   logic [15:0] csr_wr_data = '0;

   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          stall_pct = 0;

   // stimulus-side view of each button: last sample time, last press/release time,
   // and whether the button should be down
   logic [31:0] btn_ms   [NUM_BUTTONS];
   logic [31:0] btn_mark [NUM_BUTTONS];
   bit          btn_held [NUM_BUTTONS];
   logic [15:0] cfg_shadow [4];
   logic [31:0] poll_ctr = '0;

   button_press_hold_release_classifier_unit #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   button_press_hold_release_classifier_unit_checker #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Throttle the result side; stall_pct of zero gives a free-flowing receiver.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Guard against a hang: a lost result or a stuck handshake ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one sample and hold it until the transfer. Entered and left at a rising
   // edge; stall is sampled at the falling edge, where it is settled.
   task automatic send(input logic [2:0] btn, input logic [1:0] act,
                       input logic [31:0] now, input logic [31:0] poll,
                       input int send_idle);
      req_type item;
      bit      taken;
      item.button_index = btn;
      item.action       = act;
      item.now_ms       = now;
      item.poll_index   = poll;
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Drop valid, wait for every predicted event, then let the pipe run dry.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four thresholds on back-to-back edges; the block must be idle.
   task automatic write_cfg(input logic [15:0] hold_min, input logic [15:0] double_min,
                            input logic [15:0] double_max, input logic [15:0] release_min);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_HOLD_MIN;
      csr_wr_data <= hold_min;
      @(posedge clock);
      csr_index   <= CSR_DOUBLE_MIN;
      csr_wr_data <= double_min;
      @(posedge clock);
      csr_index   <= CSR_DOUBLE_MAX;
      csr_wr_data <= double_max;
      @(posedge clock);
      csr_index   <= CSR_RELEASE_MIN;
      csr_wr_data <= release_min;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_shadow[CSR_HOLD_MIN]    = hold_min;
      cfg_shadow[CSR_DOUBLE_MIN]  = double_min;
      cfg_shadow[CSR_DOUBLE_MAX]  = double_max;
      cfg_shadow[CSR_RELEASE_MIN] = release_min;
   endtask

   // Time step for a button: short gaps, long ones, and some full-range
   // jumps that wrap the 32-bit clock.
   function automatic logic [31:0] pick_delta();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45)
         return 32'($urandom_range(350));
      if (r < 80)
         return 32'($urandom_range(70000));
      return $urandom();
   endfunction

   // Offset that lands on one of the thresholds, give or take one.
   function automatic logic [31:0] near_threshold();
      return 32'(cfg_shadow[$urandom_range(3)]) + 32'($urandom_range(2)) - 32'd1;
   endfunction

   // Mostly well-formed press / hold / release runs per button, with stray releases
   // on buttons that are up and idle samples mixed in as noise.
   task automatic run_random(input int goal, input int send_idle);
      int          done_items;
      int unsigned b;
      int unsigned r;
      logic [1:0]  act;
      logic [31:0] now;
      logic [31:0] poll;
      done_items = 0;
      b = $urandom_range(NUM_BUTTONS - 1);
      while (done_items < goal) begin
         // stay on the same button half the time so holds and doubles build up
         if ($urandom_range(99) < 50)
            b = $urandom_range(NUM_BUTTONS - 1);
         r = $urandom_range(99);
         if (btn_held[b])
            act = (r < 55) ? ACT_PRESS : (r < 90) ? ACT_RELEASE :
                  (r < 95) ? ACT_IDLE : ACT_UNUSED;
         else
            act = (r < 75) ? ACT_PRESS : (r < 85) ? ACT_RELEASE :
                  (r < 93) ? ACT_IDLE : ACT_UNUSED;
         if ($urandom_range(99) < 25)
            now = btn_mark[b] + near_threshold();
         else
            now = btn_ms[b] + pick_delta();
         poll = ($urandom_range(99) < 10) ? $urandom() : poll_ctr;
         poll_ctr++;
         send(b[2:0], act, now, poll, send_idle);
         btn_ms[b] = now;
         if (act == ACT_PRESS && !btn_held[b]) begin
            btn_held[b] = 1'b1;
            btn_mark[b] = now;
         end else if (act == ACT_RELEASE && btn_held[b]) begin
            btn_held[b] = 1'b0;
            btn_mark[b] = now;
         end
         done_items++;
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         btn_ms[i]   = $urandom();
         btn_mark[i] = btn_ms[i];
         btn_held[i] = 1'b0;
      end
      cfg_shadow[CSR_HOLD_MIN]    = HOLD_MIN_RESET;
      cfg_shadow[CSR_DOUBLE_MIN]  = DOUBLE_MIN_RESET;
      cfg_shadow[CSR_DOUBLE_MAX]  = DOUBLE_MAX_RESET;
      cfg_shadow[CSR_RELEASE_MIN] = RELEASE_MIN_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset thresholds: hold 500, window 0..300, release 0.
      // Press, too-early repeat, hold at exactly the threshold, hold continuing.
      send(3'd0, ACT_PRESS,   32'd100, 32'd0, 0);
      send(3'd0, ACT_PRESS,   32'd200, 32'd1, 0);
      send(3'd0, ACT_PRESS,   32'd600, 32'd2, 0);
      send(3'd0, ACT_PRESS,   32'd650, 32'd3, 0);
      // Idle and the unused code leave the button alone.
      send(3'd0, ACT_IDLE,    32'd660, 32'd4, 0);
      send(3'd0, ACT_UNUSED,  32'd670, 32'd5, 0);
      // Release, then a release while up is ignored.
      send(3'd0, ACT_RELEASE, 32'd700, 32'd6, 0);
      send(3'd0, ACT_RELEASE, 32'd710, 32'd7, 0);
      // Double press inside the window, then a press one past its top edge.
      send(3'd0, ACT_PRESS,   32'd1000, 32'd8, 0);
      send(3'd0, ACT_RELEASE, 32'd1050, 32'd9, 0);
      send(3'd0, ACT_PRESS,   32'd1351, 32'hFFFF_FFFF, 0);
      // Time wraps through zero on the highest button.
      send(3'd7, ACT_PRESS,   32'hFFFF_FF00, 32'hFFFF_FFFF, 0);
      send(3'd7, ACT_PRESS,   32'h0000_00F4, 32'd0, 0);
      send(3'd7, ACT_RELEASE, 32'h0000_0110, 32'h8000_0000, 0);
      send(3'd7, ACT_PRESS,   32'h0000_023C, 32'h7FFF_FFFF, 0);
      drain();

      // Raise the release minimum and the window floor.
      write_cfg(16'd500, 16'd20, 16'd300, 16'd100);
      // Too-short release keeps the button down; release at exactly the minimum.
      send(3'd3, ACT_PRESS,   32'd5000, 32'd20, 0);
      send(3'd3, ACT_RELEASE, 32'd5099, 32'd21, 0);
      send(3'd3, ACT_RELEASE, 32'd5100, 32'd22, 0);
      // Gap below the window floor is a plain press; at the floor it is a double.
      send(3'd3, ACT_PRESS,   32'd5119, 32'd23, 0);
      send(3'd3, ACT_RELEASE, 32'd5300, 32'd24, 0);
      send(3'd3, ACT_PRESS,   32'd5320, 32'd25, 0);
      // Hold from a double press: one short of the threshold, then at it.
      send(3'd3, ACT_PRESS,   32'd5819, 32'd26, 0);
      send(3'd3, ACT_PRESS,   32'd5820, 32'd27, 0);
      drain();
      btn_held[0] = 1'b1;
      btn_held[3] = 1'b1;
      btn_held[7] = 1'b1;
      poll_ctr = 32'd100;

      // Random part: a new threshold set per phase and one of four idling and stall patterns.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: write_cfg(16'd0, 16'd0, 16'd0, 16'd0);
            1: write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            // window floor above its ceiling: no double presses at all
            2: write_cfg(16'd50, 16'd400, 16'd100, 16'd20);
            3: write_cfg(16'd300, 16'd40, 16'd250, 16'd30);
            5: write_cfg(16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
            6: write_cfg(HOLD_MIN_RESET, DOUBLE_MIN_RESET, DOUBLE_MAX_RESET,
                         RELEASE_MIN_RESET);
            default: write_cfg(16'($urandom_range(2000)), 16'($urandom_range(200)),
                               16'($urandom_range(600)), 16'($urandom()));
         endcase
         case (phase % 4)
            0: begin
               stall_pct <= 0;
               run_random(PHASE_ITEMS, 0);
            end
            1: begin
               stall_pct <= 0;
               run_random(PHASE_ITEMS, 75);
            end
            2: begin
               stall_pct <= 75;
               run_random(PHASE_ITEMS, 0);
            end
            default: begin
               stall_pct <= 29;
               run_random(PHASE_ITEMS, 29);
            end
         endcase
         drain();
      end

      @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
